[design/deadline_timer_queue_assert.svh]
// Assertion macros shared by the timer queue RTL.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define DTQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("deadline_timer_queue: invariant violated");

// Consequence that must hold in the same cycle as its cause.
`define DTQ_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("deadline_timer_queue: implication violated");

// Consequence that must hold in the cycle after its cause.
`define DTQ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("deadline_timer_queue: sequence violated");

`endif

[design/dtq_pkg.sv]
// Types, codes and helpers of the deadline timer queue.
package dtq_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int FIRED_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W        = 32;
    localparam int ID_W          = 32;
    localparam int DELAY_W       = 24;
    localparam int ACT_W         = 5;
    localparam int IN_W          = 80;
    localparam int OUT_W         = 40;
    localparam int USER_W        = 2;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_FIRED  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_TDECIDE,
        ST_TFLUSH,
        ST_RESP
    } state_t;

    // Command word as {tdata, tuser}: the command travels in tuser.
    typedef struct packed {
        logic [ID_W-1:0]    target_id;
        logic [DELAY_W-1:0] period;
        logic [DELAY_W-1:0] delay;
        logic [1:0]         command;
    } in_word_t;

    // Result word as {tdata, tuser}: the kind travels in tuser.
    typedef struct packed {
        logic [0:0]       pad;
        logic [ACT_W-1:0] active_count;
        logic [1:0]       status;
        logic [ID_W-1:0]  handle;
        logic [1:0]       kind;
    } out_word_t;

    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [TIME_W-1:0]  deadline;
        logic [DELAY_W-1:0] reload;
    } slot_entry_t;

    typedef struct packed {
        logic expired;
        logic older;
        logic id_match;
    } cmp_flags_t;

    function automatic out_word_t make_word(input logic [1:0] kind,
                                            input logic [ID_W-1:0] id,
                                            input logic [1:0] status,
                                            input logic [ACT_W-1:0] count);
        out_word_t w;
        w = '0;
        w.kind         = kind;
        w.handle       = id;
        w.status       = status;
        w.active_count = count;
        return w;
    endfunction

endpackage

[design/deadline_timer_queue.sv]
// Top level of the deadline timer queue: sequencer, slot flags and output register.
//
//  Channel | Ports                          | Word
//  --------+--------------------------------+--------------------------------------------
//  input   | s_tvalid s_tready s_tdata      | delay, period, target_id in tdata;
//          | s_tuser                        | command in tuser
//  result  | m_tvalid m_tready m_tdata      | handle, status, active_count in tdata;
//          | m_tuser m_tlast                | kind in tuser; m_tlast ends a command
//
// Add and cancel walk the slot store once with a single comparator, one slot per cycle,
// and then answer; cancel-all answers without a walk.
// A tick walks the store once per fired timer plus once more to find that nothing is
// left; the final walk is skipped when the count of fired timers reaches 16.
// aresetn is synchronous and active low; it empties the table, sets time to zero and
// the next identifier to one. The store needs no clearing pass, as slot flags gate it.
// A stalled result channel holds the sequencer; the input is taken only when idle.
module deadline_timer_queue #(
    parameter int SLOTS = dtq_pkg::SLOTS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // from bit 0: delay[23:0], period[23:0], target_id[31:0]
    input  logic [dtq_pkg::IN_W-1:0]   s_tdata,
    // from bit 0: command[1:0]
    input  logic [dtq_pkg::USER_W-1:0] s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // from bit 0: handle[31:0], status[1:0], active_count[4:0], zero fill
    output logic [dtq_pkg::OUT_W-1:0]  m_tdata,
    // from bit 0: kind[1:0]
    output logic [dtq_pkg::USER_W-1:0] m_tuser,
    output logic                       m_tlast
);
    import dtq_pkg::*;

    `include "deadline_timer_queue_assert.svh"

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    state_t state_reg, state_next;

    in_word_t    in_word;
    logic [1:0]  cmd_reg, cmd_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [DELAY_W-1:0] period_reg, period_next;
    logic [ID_W-1:0]    target_reg, target_next;

    logic [TIME_W-1:0] time_reg, time_next;
    logic [ID_W-1:0]   ident_reg, ident_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [SLOTS-1:0]  done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [IDX_W-1:0] scan_addr_reg, scan_addr_next;
    logic             ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0] ev_slot_reg, ev_slot_next;

    logic              best_found_reg, best_found_next;
    logic [IDX_W-1:0]  best_slot_reg, best_slot_next;
    logic [TIME_W-2:0] best_age_reg, best_age_next;
    slot_entry_t       best_entry_reg, best_entry_next;

    logic [FIRED_W-1:0] fired_reg, fired_next;
    logic               have_pend_reg, have_pend_next;
    out_word_t          pend_word_reg, pend_word_next;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;
    logic      out_last_reg, out_last_next;

    logic        ram_we;
    slot_entry_t ram_wdata;
    slot_entry_t ram_rdata;

    cmp_flags_t        flags;
    logic [TIME_W-2:0] age;
    logic [TIME_W-1:0] sum;
    logic [TIME_W-1:0] add_a, add_b;

    logic              accept, out_free, take;
    logic              slot_v, slot_d;
    logic              emit, emit_last;
    out_word_t         emit_word;
    logic [CNT_W-1:0]  cnt_after;
    logic [DELAY_W-1:0] delay_eff;

    assign in_word  = in_word_t'({s_tdata, s_tuser});
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign {m_tdata, m_tuser} = out_word_reg;
    assign m_tlast  = out_last_reg;

    assign slot_v    = valid_reg[ev_slot_reg];
    assign slot_d    = done_reg[ev_slot_reg];
    assign delay_eff = (delay_reg == '0) ? DELAY_W'(1) : delay_reg;

    dtq_slot_ram #(
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (best_slot_reg),
        .wdata (ram_wdata),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    // The adder serves the deadline of a new timer and the reload of a fired one.
    always_comb begin
        if (state_reg == ST_RESP) begin
            add_a = time_reg;
            add_b = TIME_W'(delay_eff);
        end else begin
            add_a = best_entry_reg.deadline;
            add_b = TIME_W'(best_entry_reg.reload);
        end
    end

    dtq_cmp_unit u_cmp (
        .now      (time_reg),
        .deadline (ram_rdata.deadline),
        .best_age (best_age_reg),
        .ident    (ram_rdata.ident),
        .target   (target_reg),
        .add_a    (add_a),
        .add_b    (add_b),
        .flags    (flags),
        .age      (age),
        .sum      (sum)
    );

    // Slot under evaluation joins the running choice for the current command.
    always_comb begin
        case (cmd_reg)
            CMD_TICK:   take = slot_v && !slot_d && flags.expired &&
                               (!best_found_reg || flags.older);
            CMD_ADD:    take = !slot_v && !best_found_reg;
            CMD_CANCEL: take = slot_v && flags.id_match && !best_found_reg;
            default:    take = 1'b0;
        endcase
        take = take && ev_vld_reg;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (in_word.command == CMD_CLEAR) ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_addr_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = (cmd_reg == CMD_TICK) ? ST_TDECIDE : ST_RESP;
            end
            ST_TDECIDE: begin
                if (out_free) begin
                    if (best_found_reg && (fired_reg != FIRED_W'(MAX_RESULTS - 1))) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_TFLUSH;
                    end
                end
            end
            ST_TFLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        cmd_next        = cmd_reg;
        delay_next      = delay_reg;
        period_next     = period_reg;
        target_next     = target_reg;
        time_next       = time_reg;
        ident_next      = ident_reg;
        valid_next      = valid_reg;
        done_next       = done_reg;
        cnt_next        = cnt_reg;
        scan_addr_next  = scan_addr_reg;
        ev_vld_next     = 1'b0;
        ev_slot_next    = ev_slot_reg;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_age_next   = best_age_reg;
        best_entry_next = best_entry_reg;
        fired_next      = fired_reg;
        have_pend_next  = have_pend_reg;
        pend_word_next  = pend_word_reg;
        ram_we          = 1'b0;
        ram_wdata       = best_entry_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;
        emit_word       = pend_word_reg;
        cnt_after       = cnt_reg;

        if (take) begin
            best_found_next = 1'b1;
            best_slot_next  = ev_slot_reg;
            best_age_next   = age;
            best_entry_next = ram_rdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next        = in_word.command;
                    delay_next      = in_word.delay;
                    period_next     = in_word.period;
                    target_next     = in_word.target_id;
                    scan_addr_next  = '0;
                    best_found_next = 1'b0;
                    fired_next      = '0;
                    have_pend_next  = 1'b0;
                    if (in_word.command == CMD_TICK) begin
                        time_next = time_reg + TIME_W'(1);
                        done_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                ev_vld_next    = 1'b1;
                ev_slot_next   = scan_addr_reg;
                scan_addr_next = scan_addr_reg + IDX_W'(1);
            end
            ST_TDECIDE: begin
                // A fired result is held back one round, until it is known whether it ends the tick.
                if (out_free && best_found_reg) begin
                    emit      = have_pend_reg;
                    emit_last = 1'b0;
                    emit_word = pend_word_reg;
                    done_next[best_slot_reg] = 1'b1;
                    if (best_entry_reg.reload != '0) begin
                        ram_we             = 1'b1;
                        ram_wdata.deadline = sum;
                    end else begin
                        valid_next[best_slot_reg] = 1'b0;
                        cnt_after = cnt_reg - CNT_W'(1);
                    end
                    cnt_next        = cnt_after;
                    pend_word_next  = make_word(KIND_FIRED, best_entry_reg.ident, STAT_OK,
                                                ACT_W'(cnt_after));
                    have_pend_next  = 1'b1;
                    fired_next      = fired_reg + FIRED_W'(1);
                    scan_addr_next  = '0;
                    best_found_next = 1'b0;
                end
            end
            ST_TFLUSH: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    emit_word = have_pend_reg ? pend_word_reg :
                                make_word(KIND_IDLE, '0, STAT_OK, ACT_W'(cnt_reg));
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    case (cmd_reg)
                        CMD_ADD: begin
                            if (best_found_reg) begin
                                ram_we    = 1'b1;
                                ram_wdata = '{ident: ident_reg, deadline: sum,
                                              reload: period_reg};
                                valid_next[best_slot_reg] = 1'b1;
                                cnt_after = cnt_reg + CNT_W'(1);
                                cnt_next  = cnt_after;
                                emit_word = make_word(KIND_ADD, ident_reg, STAT_OK,
                                                      ACT_W'(cnt_after));
                                // Identifier zero means no timer and is skipped on wrap.
                                ident_next = ident_reg + ID_W'(1);
                                if (ident_next == '0) begin
                                    ident_next = ID_W'(1);
                                end
                            end else begin
                                emit_word = make_word(KIND_ADD, '0, STAT_FULL,
                                                      ACT_W'(cnt_reg));
                            end
                        end
                        CMD_CANCEL: begin
                            if (best_found_reg) begin
                                valid_next[best_slot_reg] = 1'b0;
                                cnt_after = cnt_reg - CNT_W'(1);
                                cnt_next  = cnt_after;
                                emit_word = make_word(KIND_CANCEL, target_reg, STAT_OK,
                                                      ACT_W'(cnt_after));
                            end else begin
                                emit_word = make_word(KIND_CANCEL, target_reg, STAT_NOT_FOUND,
                                                      ACT_W'(cnt_reg));
                            end
                        end
                        CMD_CLEAR: begin
                            valid_next = '0;
                            cnt_next   = '0;
                            emit_word  = make_word(KIND_CANCEL, '0, STAT_OK, '0);
                        end
                        default: begin
                            emit_word = make_word(KIND_IDLE, '0, STAT_OK, ACT_W'(cnt_reg));
                        end
                    endcase
                end
            end
            default: ;
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
            out_last_next  = emit_last;
        end else begin
            out_valid_next = out_valid_reg && !m_tready;
            out_word_next  = out_word_reg;
            out_last_next  = out_last_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            time_reg       <= '0;
            ident_reg      <= ID_W'(1);
            valid_reg      <= '0;
            done_reg       <= '0;
            cnt_reg        <= '0;
            ev_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            fired_reg      <= '0;
            have_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            ident_reg      <= ident_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            cnt_reg        <= cnt_next;
            ev_vld_reg     <= ev_vld_next;
            best_found_reg <= best_found_next;
            fired_reg      <= fired_next;
            have_pend_reg  <= have_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        delay_reg      <= delay_next;
        period_reg     <= period_next;
        target_reg     <= target_next;
        scan_addr_reg  <= scan_addr_next;
        ev_slot_reg    <= ev_slot_next;
        best_slot_reg  <= best_slot_next;
        best_age_reg   <= best_age_next;
        best_entry_reg <= best_entry_next;
        pend_word_reg  <= pend_word_next;
        out_word_reg   <= out_word_next;
        out_last_reg   <= out_last_next;
    end

    // The held-timer count always agrees with the slot flags.
    `DTQ_ASSERT_ALWAYS(a_count_matches_flags, cnt_reg == CNT_W'($countones(valid_reg)))
    // An accepted word always starts work, so the input closes on the next cycle.
    `DTQ_ASSERT_NEXT(a_accept_closes_input, s_tvalid && s_tready, !s_tready)
    // A fired timer always carries a real identifier.
    `DTQ_ASSERT_IMPL(a_fired_id_nonzero, m_tvalid && (m_tuser == KIND_FIRED), m_tdata[ID_W-1:0] != '0)

endmodule

[design/dtq_slot_ram.sv]
// Slot store: identifier, deadline and reload of each timer, registered read.
module dtq_slot_ram #(
    parameter int DEPTH = dtq_pkg::SLOTS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  dtq_pkg::slot_entry_t     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output dtq_pkg::slot_entry_t     rdata
);
    import dtq_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/dtq_cmp_unit.sv]
// Shared arithmetic unit: wrap-aware age, ordering, identifier match and deadline sum.
module dtq_cmp_unit (
    input  logic [dtq_pkg::TIME_W-1:0] now,
    input  logic [dtq_pkg::TIME_W-1:0] deadline,
    input  logic [dtq_pkg::TIME_W-2:0] best_age,
    input  logic [dtq_pkg::ID_W-1:0]   ident,
    input  logic [dtq_pkg::ID_W-1:0]   target,
    input  logic [dtq_pkg::TIME_W-1:0] add_a,
    input  logic [dtq_pkg::TIME_W-1:0] add_b,
    output dtq_pkg::cmp_flags_t        flags,
    output logic [dtq_pkg::TIME_W-2:0] age,
    output logic [dtq_pkg::TIME_W-1:0] sum
);
    import dtq_pkg::*;

    logic [TIME_W-1:0] diff;

    // A timer has expired when now minus deadline lands in the lower half of the range.
    always_comb begin
        diff           = now - deadline;
        age            = diff[TIME_W-2:0];
        flags.expired  = ~diff[TIME_W-1];
        flags.older    = diff[TIME_W-2:0] > best_age;
        flags.id_match = (ident == target);
        sum            = add_a + add_b;
    end

endmodule

[test/deadline_timer_queue_tb.sv]
// Self-checking testbench for the deadline timer queue: directed, full-table and random commands.
module deadline_timer_queue_tb;

    import dtq_pkg::*;

    localparam int TABLE_SLOTS = SLOTS_DEFAULT;
    // Longest walk of the store for one command; used for the quiet spell at the end.
    localparam int WALK_CYCLES = TABLE_SLOTS + 3;

    // One expected result word, field by field, with its end-of-command flag.
    typedef struct {
        logic [1:0]       kind;
        logic [ID_W-1:0]  handle;
        logic [1:0]       status;
        logic [ACT_W-1:0] active_count;
        logic             last;
    } answer_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;
    logic [USER_W-1:0]  s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic [USER_W-1:0]  m_tuser;
    logic               m_tlast;

    // When set, neither side of the bus idles.
    bit steady = 1'b0;

    // Shadow copy of the timer table, kept in step with every accepted command.
    bit                 shadow_busy   [TABLE_SLOTS];
    logic [ID_W-1:0]    shadow_id     [TABLE_SLOTS];
    logic [TIME_W-1:0]  shadow_due    [TABLE_SLOTS];
    logic [DELAY_W-1:0] shadow_reload [TABLE_SLOTS];
    logic [TIME_W-1:0]  shadow_now;
    logic [ID_W-1:0]    shadow_next_id;

    answer_t answers_due[$];

    int fail_count    = 0;
    int words_checked = 0;
    int cmds_sent     = 0;
    int adds_taken    = 0;
    int adds_refused  = 0;
    int cancels_hit   = 0;
    int cancels_miss  = 0;
    int timers_fired  = 0;
    int empty_ticks   = 0;
    int clears_sent   = 0;
    int busiest_tick  = 0;

    deadline_timer_queue #(
        .SLOTS(TABLE_SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // A generous ceiling: even a run in which every tick fired a full table behind a
    // stalling receiver finishes far inside it.
    initial begin
        #1200000;
        $display("FAIL deadline_timer_queue");
        $finish;
    end

    // The receiver holds off in roughly a quarter of the cycles unless a steady stretch runs.
    always @(posedge aclk) begin
        if (!aresetn || steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 27);
        end
    end

    function automatic int held_total();
        int n;
        n = 0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (shadow_busy[s]) n++;
        end
        return n;
    endfunction

    function automatic answer_t make_answer(logic [1:0] kind, logic [ID_W-1:0] id,
                                            logic [1:0] status);
        answer_t a;
        a.kind         = kind;
        a.handle       = id;
        a.status       = status;
        a.active_count = ACT_W'(held_total());
        a.last         = 1'b0;
        return a;
    endfunction

    function automatic void reset_shadow();
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            shadow_busy[s]   = 1'b0;
            shadow_id[s]     = '0;
            shadow_due[s]    = '0;
            shadow_reload[s] = '0;
        end
        shadow_now     = '0;
        shadow_next_id = 1;
    endfunction

    // Applies one accepted command to the shadow table and queues the words it must produce.
    function automatic void predict_answers(in_word_t w);
        answer_t                batch[$];
        answer_t                a;
        logic [TABLE_SLOTS-1:0] fired_mask;
        logic [TIME_W-1:0]      age;
        logic [TIME_W-1:0]      best;
        logic [DELAY_W-1:0]     wait_ticks;
        int                     pick;
        int                     free_slot;
        bit                     found;

        case (w.command)
            CMD_TICK: begin
                shadow_now += 1;
                fired_mask = '0;
                // Oldest deadline first; a strict comparison leaves ties with the lower slot.
                while (batch.size() < MAX_RESULTS) begin
                    pick = -1;
                    best = '0;
                    for (int s = 0; s < TABLE_SLOTS; s++) begin
                        age = shadow_now - shadow_due[s];
                        if (shadow_busy[s] && !fired_mask[s] && !age[TIME_W-1] &&
                                (pick < 0 || age > best)) begin
                            pick = s;
                            best = age;
                        end
                    end
                    if (pick < 0) break;
                    fired_mask[pick] = 1'b1;
                    if (shadow_reload[pick] != '0) begin
                        shadow_due[pick] += TIME_W'(shadow_reload[pick]);
                    end else begin
                        shadow_busy[pick] = 1'b0;
                    end
                    batch.push_back(make_answer(KIND_FIRED, shadow_id[pick], STAT_OK));
                end
                timers_fired += batch.size();
                if (batch.size() > busiest_tick) busiest_tick = batch.size();
                if (batch.size() == 0) begin
                    empty_ticks++;
                    batch.push_back(make_answer(KIND_IDLE, '0, STAT_OK));
                end
            end
            CMD_ADD: begin
                free_slot = -1;
                for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
                    if (!shadow_busy[s]) free_slot = s;
                end
                if (free_slot < 0) begin
                    adds_refused++;
                    batch.push_back(make_answer(KIND_ADD, '0, STAT_FULL));
                end else begin
                    adds_taken++;
                    wait_ticks = (w.delay == '0) ? DELAY_W'(1) : w.delay;
                    shadow_busy[free_slot]   = 1'b1;
                    shadow_id[free_slot]     = shadow_next_id;
                    shadow_due[free_slot]    = shadow_now + TIME_W'(wait_ticks);
                    shadow_reload[free_slot] = w.period;
                    shadow_next_id += 1;
                    // Identifier zero means no timer and is never handed out.
                    if (shadow_next_id == '0) shadow_next_id = 1;
                    batch.push_back(make_answer(KIND_ADD, shadow_id[free_slot], STAT_OK));
                end
            end
            CMD_CANCEL: begin
                found = 1'b0;
                for (int s = 0; s < TABLE_SLOTS; s++) begin
                    if (!found && shadow_busy[s] && shadow_id[s] == w.target_id) begin
                        shadow_busy[s] = 1'b0;
                        found = 1'b1;
                    end
                end
                if (found) cancels_hit++;
                else cancels_miss++;
                batch.push_back(make_answer(KIND_CANCEL, w.target_id,
                                            found ? STAT_OK : STAT_NOT_FOUND));
            end
            default: begin
                clears_sent++;
                for (int s = 0; s < TABLE_SLOTS; s++) shadow_busy[s] = 1'b0;
                batch.push_back(make_answer(KIND_CANCEL, '0, STAT_OK));
            end
        endcase

        a = batch.pop_back();
        a.last = 1'b1;
        batch.push_back(a);
        foreach (batch[i]) answers_due.push_back(batch[i]);
    endfunction

    function automatic in_word_t make_cmd(logic [1:0] command, logic [DELAY_W-1:0] delay,
                                          logic [DELAY_W-1:0] period, logic [ID_W-1:0] target);
        in_word_t w;
        w           = '0;
        w.command   = command;
        w.delay     = delay;
        w.period    = period;
        w.target_id = target;
        return w;
    endfunction

    // Fields the command does not use are filled with noise so that every bit moves.
    function automatic in_word_t noisy_cmd(logic [1:0] command);
        return make_cmd(command, DELAY_W'($urandom), DELAY_W'($urandom), $urandom);
    endfunction

    // Sends one command word. The valid stays high after acceptance so that a following
    // word can go out without a bubble; the drain lowers it, and so does the next call before a gap.
    task automatic send_word(in_word_t w);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 27) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid            <= 1'b1;
        {s_tdata, s_tuser}  <= w;
        do @(posedge aclk); while (!s_tready);
        cmds_sent++;
        predict_answers(w);
    endtask

    task automatic check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Every result word is matched against the oldest expectation.
    always @(posedge aclk) begin
        out_word_t got;
        answer_t   want;
        if (aresetn && m_tvalid && m_tready) begin
            got = out_word_t'({m_tdata, m_tuser});
            words_checked++;
            if (answers_due.size() == 0) begin
                fail_count++;
                $display("%0t: result word with nothing expected, actual %h/%h last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = answers_due.pop_front();
                check_field("kind", ID_W'(want.kind), ID_W'(got.kind));
                check_field("handle", want.handle, got.handle);
                check_field("status", ID_W'(want.status), ID_W'(got.status));
                check_field("active_count", ID_W'(want.active_count), ID_W'(got.active_count));
                check_field("tlast", ID_W'(want.last), ID_W'(m_tlast));
                check_field("fill", '0, ID_W'(got.pad));
            end
        end
    end

    // Random helpers: mostly short delays and periods so that timers actually fire,
    // with the odd full-width value to move the upper bits.
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 70) return DELAY_W'($urandom_range(0, 6));
        if (r < 90) return DELAY_W'($urandom_range(7, 40));
        return DELAY_W'($urandom);
    endfunction

    function automatic logic [DELAY_W-1:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 45) return '0;
        if (r < 85) return DELAY_W'($urandom_range(1, 6));
        return DELAY_W'($urandom);
    endfunction

    // Mostly an identifier that is held, sometimes one that was freed or never issued.
    function automatic logic [ID_W-1:0] pick_target();
        int held[$];
        int r;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (shadow_busy[s]) held.push_back(s);
        end
        r = $urandom_range(99);
        if (r < 70 && held.size() > 0) return shadow_id[held[$urandom_range(held.size() - 1)]];
        if (r < 85) return shadow_next_id - ID_W'($urandom_range(1, 4));
        return $urandom;
    endfunction

    // Directed walk through every command and the corner cases of each.
    task automatic test_directed();
        send_word(make_cmd(CMD_TICK, '1, '1, '1));               // empty table: nothing fires
        send_word(make_cmd(CMD_CANCEL, '0, '0, 32'd1));          // cancel on an empty table
        send_word(make_cmd(CMD_ADD, '0, '0, '1));                // zero delay counts as one
        send_word(make_cmd(CMD_ADD, 24'd1, '0, '0));             // same deadline, next slot
        send_word(make_cmd(CMD_ADD, '1, '1, '0));                // largest delay and period
        send_word(make_cmd(CMD_ADD, 24'd2, 24'd1, '0));          // periodic, one-tick reload
        send_word(make_cmd(CMD_TICK, '0, '0, '0));               // tie goes to the lower slot
        send_word(make_cmd(CMD_TICK, '0, '0, '0));               // periodic timer fires
        send_word(make_cmd(CMD_TICK, '0, '0, '0));               // and again after reload
        send_word(make_cmd(CMD_CANCEL, '1, '1, 32'd4));          // cancel a held periodic timer
        send_word(make_cmd(CMD_CANCEL, '0, '0, 32'd4));          // the same identifier is gone
        send_word(make_cmd(CMD_CANCEL, '0, '0, 32'd0));          // the no-timer identifier
        send_word(make_cmd(CMD_CANCEL, '0, '0, '1));             // all-ones identifier
        send_word(make_cmd(CMD_ADD, 24'd3, 24'd2, '0));          // reuses the lowest free slot
        send_word(make_cmd(CMD_ADD, 24'h800000, 24'h7FFFFF, '1));
        repeat (4) send_word(noisy_cmd(CMD_TICK));
        send_word(make_cmd(CMD_CANCEL, '0, '0, 32'd3));          // the far-off timer
        send_word(make_cmd(CMD_CLEAR, '1, '1, '1));
        send_word(make_cmd(CMD_TICK, '0, '0, '0));
        send_word(make_cmd(CMD_CLEAR, '0, '0, '0));              // clearing an empty table
    endtask

    // Fills the table, refuses further adds, then fires every timer in one tick.
    task automatic test_full_table();
        logic [DELAY_W-1:0] common_delay;
        for (int round = 0; round < 3; round++) begin
            send_word(noisy_cmd(CMD_CLEAR));
            common_delay = DELAY_W'($urandom_range(0, 3));
            while (held_total() < TABLE_SLOTS) begin
                send_word(make_cmd(CMD_ADD, common_delay,
                                   DELAY_W'($urandom_range(0, 2)), $urandom));
            end
            send_word(make_cmd(CMD_ADD, pick_delay(), pick_period(), $urandom));
            send_word(make_cmd(CMD_ADD, '1, '1, '1));
            repeat ($urandom_range(4, 6)) send_word(noisy_cmd(CMD_TICK));
            repeat (3) send_word(make_cmd(CMD_CANCEL, DELAY_W'($urandom), DELAY_W'($urandom),
                                          pick_target()));
            send_word(make_cmd(CMD_ADD, pick_delay(), pick_period(), $urandom));
        end
    endtask

    // Random mix weighted towards adds and ticks so the table fills and drains repeatedly.
    task automatic test_random_mix(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            // A long stretch in the middle with both sides running flat out.
            steady = (i >= count / 3) && (i < count / 3 + 60);
            r = $urandom_range(99);
            if (r < 35) begin
                send_word(make_cmd(CMD_ADD, pick_delay(), pick_period(), $urandom));
            end else if (r < 75) begin
                send_word(noisy_cmd(CMD_TICK));
            end else if (r < 96) begin
                send_word(make_cmd(CMD_CANCEL, DELAY_W'($urandom), DELAY_W'($urandom),
                                   pick_target()));
            end else begin
                send_word(noisy_cmd(CMD_CLEAR));
            end
        end
        steady = 1'b0;
    endtask

    // Lowers the valid and waits for every expected word, then a quiet spell in which
    // any stray word would still be caught.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (2 * WALK_CYCLES) @(posedge aclk);
    endtask

    initial begin
        reset_shadow();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_table();
        test_random_mix(200);
        drain();

        $display("Sent %0d commands, checked %0d words: %0d adds, %0d refused, %0d clears.",
                 cmds_sent, words_checked, adds_taken, adds_refused, clears_sent);
        $display("Fired %0d (up to %0d a tick), %0d empty ticks, cancels %0d hit, %0d missed.",
                 timers_fired, busiest_tick, empty_ticks, cancels_hit, cancels_miss);
        if (fail_count == 0) begin
            $display("PASS deadline_timer_queue");
        end else begin
            $display("FAIL deadline_timer_queue");
        end
        $finish;
    end

endmodule
